// ===== sv/assert_macros.svh =====
// Assertion macros shared by the trace ring buffer RTL.
// Clocked on clock, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define TRB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define TRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/trb_pkg.sv =====
// Shared types, codes and defaults of the trace ring buffer.
// Used by trb_ctrl, trb_dp, trb_rem and trace_ring_buffer; no dependencies.
package trb_pkg;

   localparam int ENTRIES_DEFAULT  = 64;
   localparam int BUFFERS_DEFAULT  = 4;
   localparam int MAX_READ_DEFAULT = 63;
   localparam int LOSS_MARGIN      = 2;

   localparam int IDX_W   = 32;
   localparam int ID_W    = 3;
   localparam int LIMIT_W = 6;
   localparam int KIND_W  = 2;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_RECORD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_ID  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_REM,
      ST_ISSUE,
      ST_EMIT,
      ST_SUM
   } trb_state_type;

   typedef struct packed {
      logic accept;
      logic load_idx;
      logic mem_rd;
      logic emit_entry;
      logic emit_sum;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic long_read;
      logic rem_done;
      logic read_more;
   } dp_status_type;

endpackage

// ===== sv/trb_ctrl.sv =====
// Controller state machine of the trace ring buffer.
// Depends on trb_pkg and assert_macros.svh; drives commands into trb_dp.
`include "assert_macros.svh"

module trb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  trb_pkg::dp_status_type status,
   output trb_pkg::ctrl_cmd_type  cmd
);

   trb_pkg::trb_state_type state_ff, state_in;

   assign req_stall = !((state_ff == trb_pkg::ST_IDLE) && status.out_free);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         trb_pkg::ST_IDLE: begin
            if (req_valid && status.out_free && status.long_read) begin
               state_in = trb_pkg::ST_LOAD;
            end
         end
         trb_pkg::ST_LOAD: begin
            state_in = trb_pkg::ST_REM;
         end
         trb_pkg::ST_REM: begin
            if (status.rem_done) begin
               state_in = trb_pkg::ST_ISSUE;
            end
         end
         trb_pkg::ST_ISSUE: begin
            if (status.read_more) begin
               state_in = trb_pkg::ST_EMIT;
            end else begin
               state_in = trb_pkg::ST_SUM;
            end
         end
         trb_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = trb_pkg::ST_ISSUE;
            end
         end
         trb_pkg::ST_SUM: begin
            if (status.out_free) begin
               state_in = trb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         trb_pkg::ST_IDLE: begin
            cmd.accept = req_valid && status.out_free;
         end
         trb_pkg::ST_LOAD: begin
            cmd.load_idx = 1'b1;
         end
         trb_pkg::ST_REM: begin
         end
         trb_pkg::ST_ISSUE: begin
            cmd.mem_rd = status.read_more;
         end
         trb_pkg::ST_EMIT: begin
            cmd.emit_entry = status.out_free;
         end
         trb_pkg::ST_SUM: begin
            cmd.emit_sum = status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `TRB_ASSERT(a_emit_from_issue, (state_ff == trb_pkg::ST_EMIT && $past(state_ff) != trb_pkg::ST_EMIT) |-> $past(state_ff) == trb_pkg::ST_ISSUE, "entry emit entered without a store read")
   `TRB_ASSERT(a_sum_from_issue, (state_ff == trb_pkg::ST_SUM && $past(state_ff) != trb_pkg::ST_SUM) |-> $past(state_ff) == trb_pkg::ST_ISSUE, "summary entered from an unexpected state")

endmodule

// ===== sv/trb_rem.sv =====
// Ring slot of the first read index, found from the buffer's write slot and the
// distance back from its counter. Depends on trb_pkg and assert_macros.svh; used by trb_dp.
`include "assert_macros.svh"

module trb_rem #(
   parameter int ENTRIES = trb_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [$clog2(ENTRIES+1)-1:0]      write_slot,
   input  logic [trb_pkg::IDX_W-1:0]         distance,
   output logic                              done,
   output logic [$clog2(ENTRIES+1)-1:0]      remainder
);

   localparam int IDX_W  = trb_pkg::IDX_W;
   localparam int SLOT_W = $clog2(ENTRIES + 1);
   localparam int SUM_W  = SLOT_W + 1;

   logic              in_ring;
   logic [SLOT_W-1:0] dist_slot;
   logic [SUM_W-1:0]  wrapped;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic              done_ff;

   // Only a distance inside one ring length names a stored entry.
   assign in_ring   = (distance < IDX_W'(ENTRIES));
   assign dist_slot = distance[SLOT_W-1:0];
   assign wrapped   = {1'b0, write_slot} + SUM_W'(ENTRIES) - {1'b0, dist_slot};

   always_comb begin
      priority if (!in_ring) begin
         rem_in = '0;
      end else if (dist_slot <= write_slot) begin
         rem_in = write_slot - dist_slot;
      end else begin
         rem_in = wrapped[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   `TRB_ASSERT(a_rem_in_ring, done |-> (rem_ff < SLOT_W'(ENTRIES)), "slot outside the ring")
   `TRB_ASSERT_NEXT(a_done_follows, start, done, "slot not ready after start")

endmodule

// ===== sv/trb_dp.sv =====
// Datapath of the trace ring buffer: counters, entry store, read cursor,
// output register. Depends on trb_pkg, trb_rem and assert_macros.svh.
`include "assert_macros.svh"

module trb_dp #(
   parameter int ENTRIES  = trb_pkg::ENTRIES_DEFAULT,
   parameter int BUFFERS  = trb_pkg::BUFFERS_DEFAULT,
   parameter int MAX_READ = trb_pkg::MAX_READ_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_operation,
   input  logic [trb_pkg::ID_W-1:0]      req_buffer_id,
   input  logic [trb_pkg::IDX_W-1:0]     req_event_payload,
   input  logic [trb_pkg::IDX_W-1:0]     req_time_stamp,
   input  logic [trb_pkg::IDX_W-1:0]     req_read_from,
   input  logic [trb_pkg::LIMIT_W-1:0]   req_read_limit,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [trb_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [trb_pkg::IDX_W-1:0]     rsp_seq_number,
   output logic [trb_pkg::IDX_W-1:0]     rsp_entry_time,
   output logic [trb_pkg::IDX_W-1:0]     rsp_entry_data,
   output logic [trb_pkg::IDX_W-1:0]     rsp_position,
   output logic [trb_pkg::LIMIT_W-1:0]   rsp_delivered,
   output logic                          rsp_more_pending,
   output logic                          rsp_last,
   input  trb_pkg::ctrl_cmd_type         cmd,
   output trb_pkg::dp_status_type        status
);

   localparam int IDX_W     = trb_pkg::IDX_W;
   localparam int LIMIT_W   = trb_pkg::LIMIT_W;
   localparam int SLOTS     = ENTRIES + 1;
   localparam int DEPTH     = BUFFERS * SLOTS;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int BUF_W     = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
   localparam int START_GAP = ENTRIES - trb_pkg::LOSS_MARGIN;
   localparam int WORD_W    = 3 * IDX_W;

   // Configuration and global state.
   logic                  recording_ff;
   logic [IDX_W-1:0]      seq_ff, seq_in;
   logic [IDX_W-1:0]      cnt_ff  [BUFFERS];
   logic [IDX_W-1:0]      cnt_in  [BUFFERS];
   logic [SLOT_W-1:0]     wptr_ff [BUFFERS];
   logic [SLOT_W-1:0]     wptr_in [BUFFERS];

   // Entry store: {seq, time, data} per slot.
   logic [WORD_W-1:0]     mem [DEPTH];
   logic [WORD_W-1:0]     rd_word_ff;

   // Read cursor.
   logic [BUF_W-1:0]      rd_buf_ff;
   logic [IDX_W-1:0]      rd_end_ff;
   logic [IDX_W-1:0]      rd_from_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [SLOT_W-1:0]     rd_slot_ff;
   logic [LIMIT_W-1:0]    rd_limit_ff;
   logic [LIMIT_W-1:0]    rd_pos_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic [trb_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [IDX_W-1:0]      seq_out_ff, seq_out_in;
   logic [IDX_W-1:0]      time_out_ff, time_out_in;
   logic [IDX_W-1:0]      data_out_ff, data_out_in;
   logic [IDX_W-1:0]      pos_out_ff, pos_out_in;
   logic [LIMIT_W-1:0]    deliv_out_ff, deliv_out_in;
   logic                  more_out_ff, more_out_in;
   logic                  last_out_ff, last_out_in;

   logic [BUF_W-1:0]      sel_buf;
   logic                  bad_id;
   logic                  is_record;
   logic                  long_read;
   logic                  do_record;
   logic [IDX_W-1:0]      sel_cnt;
   logic [SLOT_W-1:0]     sel_wptr;
   logic [SLOT_W-1:0]     wr_slot;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [LIMIT_W-1:0]    clip_limit;
   logic [IDX_W-1:0]      start_idx;
   logic [IDX_W-1:0]      first_idx;
   logic [IDX_W-1:0]      rd_dist;
   logic [SLOT_W-1:0]     rd_wptr;
   logic                  idx_below_end;
   logic                  read_more;
   logic                  out_free;
   logic                  load_out;
   logic                  rem_done;
   logic [SLOT_W-1:0]     rem_out;

   assign sel_buf   = req_buffer_id[BUF_W-1:0];
   assign bad_id    = {1'b0, req_buffer_id} >= (trb_pkg::ID_W + 1)'(BUFFERS);
   assign is_record = (req_operation == trb_pkg::OP_RECORD);
   assign long_read = !bad_id && !is_record && (req_read_limit != '0);
   assign do_record = cmd.accept && is_record && !bad_id;
   assign sel_cnt   = cnt_ff[sel_buf];
   assign sel_wptr  = wptr_ff[sel_buf];
   assign seq_in    = seq_ff + IDX_W'(1);

   assign wr_slot = recording_ff ? sel_wptr : SLOT_W'(ENTRIES);
   assign wr_addr = ADDR_W'(sel_buf) * ADDR_W'(SLOTS) + ADDR_W'(wr_slot);
   assign rd_addr = ADDR_W'(rd_buf_ff) * ADDR_W'(SLOTS) + ADDR_W'(rd_slot_ff);

   assign clip_limit = (req_read_limit > LIMIT_W'(MAX_READ)) ? LIMIT_W'(MAX_READ)
                                                             : req_read_limit;

   // Skip forward past entries that may have been overwritten.
   assign start_idx = (rd_end_ff >= IDX_W'(START_GAP)) ? rd_end_ff - IDX_W'(START_GAP) : '0;
   assign first_idx = (rd_from_ff < start_idx) ? start_idx : rd_from_ff;

   // Locate the first slot by stepping back from the write slot.
   assign rd_dist = rd_end_ff - first_idx;
   assign rd_wptr = wptr_ff[rd_buf_ff];

   assign idx_below_end = (rd_idx_ff < rd_end_ff);
   assign read_more     = idx_below_end && (rd_pos_ff < rd_limit_ff);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign load_out      = (cmd.accept && !long_read) || cmd.emit_entry || cmd.emit_sum;

   assign status.out_free  = out_free;
   assign status.long_read = long_read;
   assign status.rem_done  = rem_done;
   assign status.read_more = read_more;

   trb_rem #(
      .ENTRIES (ENTRIES)
   ) u_rem (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.load_idx),
      .write_slot (rd_wptr),
      .distance   (rd_dist),
      .done       (rem_done),
      .remainder  (rem_out)
   );

   always_comb begin
      cnt_in  = cnt_ff;
      wptr_in = wptr_ff;
      if (do_record && recording_ff) begin
         cnt_in[sel_buf] = sel_cnt + IDX_W'(1);
         // Restart the slot when the counter wraps, too.
         wptr_in[sel_buf] = (sel_wptr == SLOT_W'(ENTRIES - 1) || sel_cnt == '1)
                            ? '0 : sel_wptr + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recording_ff <= 1'b1;
         seq_ff       <= '0;
         for (int b = 0; b < BUFFERS; b++) begin
            cnt_ff[b]  <= '0;
            wptr_ff[b] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            recording_ff <= csr_write_data;
         end
         if (do_record) begin
            seq_ff <= seq_in;
         end
         cnt_ff  <= cnt_in;
         wptr_ff <= wptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_record) begin
         mem[wr_addr] <= {seq_in, req_time_stamp, req_event_payload};
      end
      if (cmd.mem_rd) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && long_read) begin
         rd_buf_ff   <= sel_buf;
         rd_end_ff   <= sel_cnt;
         rd_from_ff  <= req_read_from;
         rd_limit_ff <= clip_limit;
         rd_pos_ff   <= '0;
      end else if (cmd.emit_entry) begin
         rd_pos_ff <= rd_pos_ff + LIMIT_W'(1);
      end
      if (cmd.load_idx) begin
         rd_idx_ff <= first_idx;
      end else if (cmd.emit_entry) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
      if (rem_done) begin
         rd_slot_ff <= rem_out;
      end else if (cmd.emit_entry) begin
         rd_slot_ff <= (rd_slot_ff == SLOT_W'(ENTRIES - 1)) ? '0 : rd_slot_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      kind_in      = trb_pkg::KIND_RECORD;
      seq_out_in   = '0;
      time_out_in  = '0;
      data_out_in  = '0;
      pos_out_in   = '0;
      deliv_out_in = '0;
      more_out_in  = 1'b0;
      last_out_in  = 1'b1;
      priority if (cmd.emit_entry) begin
         kind_in     = trb_pkg::KIND_ENTRY;
         seq_out_in  = rd_word_ff[WORD_W-1 -: IDX_W];
         time_out_in = rd_word_ff[2*IDX_W-1 -: IDX_W];
         data_out_in = rd_word_ff[IDX_W-1:0];
         pos_out_in  = rd_idx_ff;
         last_out_in = 1'b0;
      end else if (cmd.emit_sum) begin
         kind_in      = trb_pkg::KIND_SUMMARY;
         pos_out_in   = rd_idx_ff;
         deliv_out_in = rd_pos_ff;
         more_out_in  = idx_below_end;
      end else if (bad_id) begin
         kind_in = trb_pkg::KIND_BAD_ID;
      end else if (is_record) begin
         kind_in    = trb_pkg::KIND_RECORD;
         seq_out_in = seq_in;
      end else begin
         // position query
         kind_in    = trb_pkg::KIND_SUMMARY;
         pos_out_in = sel_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         kind_ff      <= kind_in;
         seq_out_ff   <= seq_out_in;
         time_out_ff  <= time_out_in;
         data_out_ff  <= data_out_in;
         pos_out_ff   <= pos_out_in;
         deliv_out_ff <= deliv_out_in;
         more_out_ff  <= more_out_in;
         last_out_ff  <= last_out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_seq_number   = seq_out_ff;
   assign rsp_entry_time   = time_out_ff;
   assign rsp_entry_data   = data_out_ff;
   assign rsp_position     = pos_out_ff;
   assign rsp_delivered    = deliv_out_ff;
   assign rsp_more_pending = more_out_ff;
   assign rsp_last         = last_out_ff;

   `TRB_ASSERT(a_no_overwrite, load_out |-> (!rsp_valid_ff || !rsp_stall), "result overwritten")
   `TRB_ASSERT(a_emit_in_range, cmd.emit_entry |-> read_more, "entry past limit or counter")
   `TRB_ASSERT_NEXT(a_slot_range, rem_done, rd_slot_ff < SLOT_W'(ENTRIES), "slot outside ring")

endmodule

// ===== sv/trace_ring_buffer.sv =====
// Trace ring buffer top level. Record, bad id and position query: result in the output
// register the cycle after the transfer, one item per cycle while the output is not stalled.
// Read with nonzero limit: clamp the index, locate its ring slot, then a store read and an
// emit per entry, find the end and emit the summary; the next item is taken once the summary
// is registered, the controller is back in idle and the output register is free.
// Reset (synchronous): counters and sequence cleared, recording on, output empty, store undefined.
module trace_ring_buffer #(
   parameter int ENTRIES  = trb_pkg::ENTRIES_DEFAULT,
   parameter int BUFFERS  = trb_pkg::BUFFERS_DEFAULT,
   parameter int MAX_READ = trb_pkg::MAX_READ_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [trb_pkg::ID_W-1:0]      req_buffer_id,
   input  logic [trb_pkg::IDX_W-1:0]     req_event_payload,
   input  logic [trb_pkg::IDX_W-1:0]     req_time_stamp,
   input  logic [trb_pkg::IDX_W-1:0]     req_read_from,
   input  logic [trb_pkg::LIMIT_W-1:0]   req_read_limit,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [trb_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [trb_pkg::IDX_W-1:0]     rsp_seq_number,
   output logic [trb_pkg::IDX_W-1:0]     rsp_entry_time,
   output logic [trb_pkg::IDX_W-1:0]     rsp_entry_data,
   output logic [trb_pkg::IDX_W-1:0]     rsp_position,
   output logic [trb_pkg::LIMIT_W-1:0]   rsp_delivered,
   output logic                          rsp_more_pending,
   output logic                          rsp_last
);

   trb_pkg::ctrl_cmd_type  cmd;
   trb_pkg::dp_status_type status;

   trb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   trb_dp #(
      .ENTRIES  (ENTRIES),
      .BUFFERS  (BUFFERS),
      .MAX_READ (MAX_READ)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_buffer_id     (req_buffer_id),
      .req_event_payload (req_event_payload),
      .req_time_stamp    (req_time_stamp),
      .req_read_from     (req_read_from),
      .req_read_limit    (req_read_limit),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_seq_number    (rsp_seq_number),
      .rsp_entry_time    (rsp_entry_time),
      .rsp_entry_data    (rsp_entry_data),
      .rsp_position      (rsp_position),
      .rsp_delivered     (rsp_delivered),
      .rsp_more_pending  (rsp_more_pending),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ===== test/trace_ring_buffer_tb.sv =====
// Self-checking testbench for trace_ring_buffer: random and directed records and reads.
// Holds its own ring model in a small scoreboard class; needs trb_pkg and the RTL only.
module trace_ring_buffer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W       = trb_pkg::IDX_W;
   localparam int ID_W        = trb_pkg::ID_W;
   localparam int LIMIT_W     = trb_pkg::LIMIT_W;
   localparam int KIND_W      = trb_pkg::KIND_W;
   localparam int ENTRIES     = trb_pkg::ENTRIES_DEFAULT;
   localparam int BUFFERS     = trb_pkg::BUFFERS_DEFAULT;
   localparam int MAX_READ    = trb_pkg::MAX_READ_DEFAULT;
   localparam int SLOTS_PER   = ENTRIES + 1;
   localparam int STORE_SLOTS = BUFFERS * SLOTS_PER;
   localparam bit [IDX_W-1:0] LOSS_BOUND = ENTRIES - trb_pkg::LOSS_MARGIN;

   typedef struct {
      bit                 op;
      bit [ID_W-1:0]      buffer_id;
      bit [IDX_W-1:0]     payload;
      bit [IDX_W-1:0]     stamp;
      bit [IDX_W-1:0]     read_from;
      bit [LIMIT_W-1:0]   limit;
   } trace_req_type;

   typedef struct {
      bit [KIND_W-1:0]    kind;
      bit [IDX_W-1:0]     seq;
      bit [IDX_W-1:0]     stamp;
      bit [IDX_W-1:0]     data;
      bit [IDX_W-1:0]     position;
      bit [LIMIT_W-1:0]   delivered;
      bit                 more;
      bit                 last;
   } trace_rsp_type;

   class trace_scoreboard;
      bit             rec_on;
      bit [IDX_W-1:0] wr_count [BUFFERS];
      bit [IDX_W-1:0] seq_last;
      bit [IDX_W-1:0] seq_mem   [STORE_SLOTS];
      bit [IDX_W-1:0] stamp_mem [STORE_SLOTS];
      bit [IDX_W-1:0] data_mem  [STORE_SLOTS];
      trace_rsp_type  expected_q [$];
      int             mismatches;

      function new();
         rec_on = 1'b1;
         foreach (wr_count[i]) wr_count[i] = '0;
         seq_last = '0;
         mismatches = 0;
      endfunction

      function void set_recording(bit v);
         rec_on = v;
      endfunction

      function bit [IDX_W-1:0] ring_count(bit [ID_W-1:0] id);
         if (id < BUFFERS) return wr_count[id];
         return '0;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function void queue_result(bit [KIND_W-1:0] kind, bit [IDX_W-1:0] seq,
                                 bit [IDX_W-1:0] stamp, bit [IDX_W-1:0] data,
                                 bit [IDX_W-1:0] position, bit [LIMIT_W-1:0] delivered,
                                 bit more, bit last);
         trace_rsp_type r;
         r.kind = kind;
         r.seq = seq;
         r.stamp = stamp;
         r.data = data;
         r.position = position;
         r.delivered = delivered;
         r.more = more;
         r.last = last;
         expected_q.push_back(r);
      endfunction

      // Work out every result that one accepted transfer causes.
      function void note_request(trace_req_type rq);
         int             base;
         int             slot;
         int             n;
         int             lim;
         bit [IDX_W-1:0] top;
         bit [IDX_W-1:0] low;
         bit [IDX_W-1:0] idx;
         if (rq.buffer_id >= BUFFERS) begin
            queue_result(trb_pkg::KIND_BAD_ID, '0, '0, '0, '0, '0, 1'b0, 1'b1);
            return;
         end
         base = rq.buffer_id * SLOTS_PER;
         if (rq.op == trb_pkg::OP_RECORD) begin
            if (rec_on) begin
               slot = base + int'(wr_count[rq.buffer_id] % ENTRIES);
               wr_count[rq.buffer_id] = wr_count[rq.buffer_id] + 1;
            end else begin
               slot = base + ENTRIES;
            end
            seq_last = seq_last + 1;
            seq_mem[slot] = seq_last;
            stamp_mem[slot] = rq.stamp;
            data_mem[slot] = rq.payload;
            queue_result(trb_pkg::KIND_RECORD, seq_last, '0, '0, '0, '0, 1'b0, 1'b1);
            return;
         end
         top = wr_count[rq.buffer_id];
         if (rq.limit == 0) begin
            queue_result(trb_pkg::KIND_SUMMARY, '0, '0, '0, top, '0, 1'b0, 1'b1);
            return;
         end
         lim = (rq.limit > MAX_READ) ? MAX_READ : int'(rq.limit);
         // Skip entries that may already be overwritten.
         low = (top >= LOSS_BOUND) ? top - LOSS_BOUND : '0;
         idx = (rq.read_from < low) ? low : rq.read_from;
         n = 0;
         while (n < lim && idx < top) begin
            slot = base + int'(idx % ENTRIES);
            queue_result(trb_pkg::KIND_ENTRY, seq_mem[slot], stamp_mem[slot], data_mem[slot],
                         idx, '0, 1'b0, 1'b0);
            n++;
            idx = idx + 1;
         end
         queue_result(trb_pkg::KIND_SUMMARY, '0, '0, '0, idx, LIMIT_W'(n), idx < top, 1'b1);
      endfunction

      function void compare_field(string name, bit [IDX_W-1:0] exp_v, bit [IDX_W-1:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      function void check_result(trace_rsp_type got);
         trace_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result of kind %0d with nothing expected", got.kind);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("result_kind", want.kind, got.kind);
         compare_field("seq_number", want.seq, got.seq);
         compare_field("entry_time", want.stamp, got.stamp);
         compare_field("entry_data", want.data, got.data);
         compare_field("position", want.position, got.position);
         compare_field("delivered", want.delivered, got.delivered);
         compare_field("more_pending", want.more, got.more);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_operation = 1'b0;
   logic [ID_W-1:0]      req_buffer_id = '0;
   logic [IDX_W-1:0]     req_event_payload = '0;
   logic [IDX_W-1:0]     req_time_stamp = '0;
   logic [IDX_W-1:0]     req_read_from = '0;
   logic [LIMIT_W-1:0]   req_read_limit = '0;
   logic                 csr_write_enable = 1'b0;
   logic                 csr_write_data = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [KIND_W-1:0]    rsp_result_kind;
   logic [IDX_W-1:0]     rsp_seq_number;
   logic [IDX_W-1:0]     rsp_entry_time;
   logic [IDX_W-1:0]     rsp_entry_data;
   logic [IDX_W-1:0]     rsp_position;
   logic [LIMIT_W-1:0]   rsp_delivered;
   logic                 rsp_more_pending;
   logic                 rsp_last;

   trace_scoreboard sb = new();
   int              steady_left = 0;
   bit              pressure_armed = 1'b0;

   trace_ring_buffer #(
      .ENTRIES (ENTRIES),
      .BUFFERS (BUFFERS),
      .MAX_READ(MAX_READ)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_buffer_id    (req_buffer_id),
      .req_event_payload(req_event_payload),
      .req_time_stamp   (req_time_stamp),
      .req_read_from    (req_read_from),
      .req_read_limit   (req_read_limit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_seq_number   (rsp_seq_number),
      .rsp_entry_time   (rsp_entry_time),
      .rsp_entry_data   (rsp_entry_data),
      .rsp_position     (rsp_position),
      .rsp_delivered    (rsp_delivered),
      .rsp_more_pending (rsp_more_pending),
      .rsp_last         (rsp_last)
   );

   always #4 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(12, 24);
   endfunction

   function automatic trace_req_type build_req(bit op, bit [ID_W-1:0] id,
                                               bit [IDX_W-1:0] payload,
                                               bit [IDX_W-1:0] stamp,
                                               bit [IDX_W-1:0] read_from,
                                               bit [LIMIT_W-1:0] limit);
      trace_req_type rq;
      rq.op = op;
      rq.buffer_id = id;
      rq.payload = payload;
      rq.stamp = stamp;
      rq.read_from = read_from;
      rq.limit = limit;
      return rq;
   endfunction

   function automatic trace_req_type random_req();
      return build_req(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 7)), $urandom,
                       $urandom, $urandom, LIMIT_W'($urandom_range(0, 63)));
   endfunction

   function automatic bit [ID_W-1:0] pick_buffer();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return ID_W'($urandom_range(BUFFERS, 7));
      if (r < 10) return '0;
      return ID_W'($urandom_range(0, BUFFERS - 1));
   endfunction

   // Read aimed around the buffer's current counter.
   function automatic trace_req_type make_read(bit [ID_W-1:0] id);
      trace_req_type  rq;
      bit [IDX_W-1:0] cnt;
      rq = random_req();
      rq.op = trb_pkg::OP_READ;
      rq.buffer_id = id;
      cnt = sb.ring_count(id);
      case ($urandom_range(0, 5))
         0: rq.read_from = '0;
         1: rq.read_from = cnt - $urandom_range(0, 70);
         2: rq.read_from = $urandom;
         3: rq.read_from = cnt;
         4: rq.read_from = cnt - $urandom_range(1, 8);
         default: rq.read_from = cnt + $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
         0: rq.limit = '0;
         1: rq.limit = 6'd63;
         2: rq.limit = LIMIT_W'($urandom_range(0, 63));
         default: rq.limit = LIMIT_W'($urandom_range(1, 8));
      endcase
      return rq;
   endfunction

   task automatic push_request(input trace_req_type rq);
      int gap;
      gap = 0;
      req_valid <= 1'b1;
      req_operation <= rq.op;
      req_buffer_id <= rq.buffer_id;
      req_event_payload <= rq.payload;
      req_time_stamp <= rq.stamp;
      req_read_from <= rq.read_from;
      req_read_limit <= rq.limit;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(rq);
      if (steady_left > 0) begin
         steady_left--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 19) == 0) steady_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected result is in.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_recording(input bit v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      sb.set_recording(v);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(input int n_items);
      int            sent;
      int            burst;
      bit [ID_W-1:0] id;
      trace_req_type rq;
      sent = 0;
      while (sent < n_items) begin
         id = pick_buffer();
         if ($urandom_range(0, 9) < 7) begin
            // Record burst followed by a read of the same buffer.
            burst = (id == 0) ? $urandom_range(2, 20) : $urandom_range(1, 8);
            repeat (burst) begin
               rq = random_req();
               rq.op = trb_pkg::OP_RECORD;
               rq.buffer_id = id;
               push_request(rq);
               sent++;
            end
            push_request(make_read(id));
            sent++;
         end else begin
            push_request(random_req());
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_recording(1'b1);

      push_request(build_req(trb_pkg::OP_READ, 3'd0, '0, '0, '0, 6'd0));
      push_request(build_req(trb_pkg::OP_READ, 3'd0, '0, '0, '0, 6'd5));
      push_request(build_req(trb_pkg::OP_RECORD, 3'd0, '0, '0, '1, 6'd63));
      push_request(build_req(trb_pkg::OP_RECORD, 3'd0, '1, '1, '0, 6'd0));
      push_request(build_req(trb_pkg::OP_RECORD, 3'd3, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0, '0));
      push_request(build_req(trb_pkg::OP_RECORD, 3'd7, '1, '1, '1, 6'd63));
      push_request(build_req(trb_pkg::OP_READ, 3'd4, '0, '0, '0, 6'd63));
      push_request(build_req(trb_pkg::OP_READ, 3'd5, '0, '0, '0, 6'd0));
      push_request(build_req(trb_pkg::OP_READ, 3'd7, '1, '1, '1, 6'd63));
      push_request(build_req(trb_pkg::OP_READ, 3'd0, '0, '0, '0, 6'd63));
      push_request(build_req(trb_pkg::OP_READ, 3'd0, '0, '0, 32'd1, 6'd1));
      push_request(build_req(trb_pkg::OP_READ, 3'd0, '0, '0, '0, 6'd1));
      push_request(build_req(trb_pkg::OP_READ, 3'd0, '0, '0, '1, 6'd63));
      push_request(build_req(trb_pkg::OP_READ, 3'd3, '0, '0, '0, 6'd0));
      push_request(build_req(trb_pkg::OP_READ, 3'd3, '0, '0, '0, 6'd63));
      settle();

      // Records now land in the spare slot; counters hold.
      set_recording(1'b0);
      push_request(build_req(trb_pkg::OP_RECORD, 3'd0, $urandom, $urandom, '0, '0));
      push_request(build_req(trb_pkg::OP_RECORD, 3'd1, $urandom, $urandom, '0, '0));
      push_request(build_req(trb_pkg::OP_READ, 3'd0, '0, '0, '0, 6'd0));
      push_request(build_req(trb_pkg::OP_READ, 3'd0, '0, '0, '0, 6'd63));
      run_random(40);
      settle();

      set_recording(1'b1);
      pressure_armed = 1'b1;
      run_random(130);
      settle();

      set_recording(1'b0);
      run_random(40);
      settle();

      set_recording(1'b1);
      run_random(80);
      settle();
      repeat (40) @(posedge clock);

      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : response_side
      trace_rsp_type got;
      int            hold;
      int            quiet;
      bit            pressure_done;
      hold = 0;
      quiet = 0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.kind = rsp_result_kind;
            got.seq = rsp_seq_number;
            got.stamp = rsp_entry_time;
            got.data = rsp_entry_data;
            got.position = rsp_position;
            got.delivered = rsp_delivered;
            got.more = rsp_more_pending;
            got.last = rsp_last;
            sb.check_result(got);
         end
         // Hold off once for a long stretch so the block backs up into its input.
         if (pressure_armed && !pressure_done) begin
            hold = 250;
            pressure_done = 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else if (quiet > 0) begin
            quiet--;
         end else if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(30, 80);
         end else begin
            hold = pick_gap();
         end
         rsp_stall <= (hold > 0);
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
